// ===== hdl/kwsm_pkg.sv =====
// ----------------------------------------------------------------------------
// kwsm_pkg
// Shared types and constants for the k-way sorted list merge block.
// ----------------------------------------------------------------------------
package kwsm_pkg;

    localparam int MaxListsDefault  = 4;
    localparam int ListDepthDefault = 16;
    localparam int CfgLanes         = 3;
    localparam logic [2:0] ListsInUseReset = 3'd3;

    localparam logic CmdAppend = 1'b0;
    localparam logic CmdMerge  = 1'b1;

    localparam logic [0:0] RegListsInUse = 1'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHOOSE,
        ST_EMIT,
        ST_EMPTY
    } t_state;

endpackage

// ===== hdl/kwsm_store.sv =====
// ----------------------------------------------------------------------------
// kwsm_store
// List storage memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module kwsm_store #(
    parameter int AW = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [2**AW];
    logic [31:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/k_way_sorted_list_merge.sv =====
// ----------------------------------------------------------------------------
// k_way_sorted_list_merge
// Holds up to MAX_LISTS lists in one memory and emits their merge.
// ----------------------------------------------------------------------------
// Channel  | Direction | Contents
// s_axis   | in        | tdata: value[31:0]; tuser: command[0], list_select[2:1]
// m_axis   | out       | tdata: merged_value; tlast: last; tuser: empty_res, overflowed
// apb      | in        | register 0 lists_in_use at address 0
//
// An append request is taken in the idle state. A merge request is accepted in
// the idle state; each merged value then takes a read state and a choose state for
// every one of the n lists in use, then the emit state, which waits for the output.
// An empty merge passes through the read state and gives its single result.
// Reset is synchronous; the store needs none. A stalled output holds the block
// in its emit state, and no request is taken until the last value has left.
module k_way_sorted_list_merge #(
    parameter int MAX_LISTS  = kwsm_pkg::MaxListsDefault,
    parameter int LIST_DEPTH = kwsm_pkg::ListDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value[31:0]
    input  logic [2:0]  s_axis_tuser,   // command[0], list_select[2:1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // merged_value[31:0]
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser,   // empty_res[0], overflowed[1]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LW = $clog2(MAX_LISTS);
    localparam int DW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int AW = LW + DW;

    kwsm_pkg::t_state r_state, n_state;
    logic [2:0]    r_cfg;
    logic [CW-1:0] r_len [MAX_LISTS];
    logic [CW-1:0] r_pos [MAX_LISTS];
    logic          r_drop;
    logic [LW-1:0] r_ptr;           // scan step within the current value
    logic [LW-1:0] r_start;         // first list of the scan order
    logic [LW-1:0] r_best;
    logic          r_have;
    logic [31:0]   r_bval;
    logic [LW:0]   r_nuse;
    logic [31:0]   r_out;
    logic          r_last;
    logic [CW+LW:0] r_left;

    logic          app_fire, mrg_fire, out_fire, cfg_we;
    logic [1:0]    sel;
    logic          sel_ok, full;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   rdata;
    logic [LW-1:0] sel_l;
    logic [LW:0]   cur_sum;
    logic [LW-1:0] cur;
    logic          cur_ok, take, scan_end;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == kwsm_pkg::RegListsInUse);
    assign prdata = (paddr[2] == kwsm_pkg::RegListsInUse) ? {29'd0, r_cfg} : 32'd0;

    assign sel   = s_axis_tuser[2:1];
    assign sel_ok = (32'(sel) < MAX_LISTS);
    assign sel_l = LW'(sel);
    assign full  = r_len[sel_l] >= CW'(LIST_DEPTH);
    assign s_axis_tready = (r_state == kwsm_pkg::ST_IDLE);
    assign app_fire = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == kwsm_pkg::CmdAppend);
    assign mrg_fire = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == kwsm_pkg::CmdMerge);
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // The pairwise queue merge is a tournament whose leaves, read in order, are
    // the lists rotated to start at r_start; scanning in that order and letting
    // a later list win ties gives the same choice at every step.
    assign cur_sum  = {1'b0, r_start} + {1'b0, r_ptr};
    assign cur      = (cur_sum >= r_nuse) ? LW'(cur_sum - r_nuse) : LW'(cur_sum);
    assign cur_ok   = r_pos[cur] < r_len[cur];
    assign take     = cur_ok && (!r_have || !($signed(r_bval) < $signed(rdata)));
    assign scan_end = ({1'b0, r_ptr} + 1'b1 >= r_nuse);

    assign waddr = {sel_l, DW'(r_len[sel_l])};
    assign raddr = {cur, DW'(r_pos[cur])};

    kwsm_store #(.AW(AW)) u_store (
        .i_clk  (i_clk),
        .i_we   (app_fire && sel_ok && !full),
        .i_waddr(waddr),
        .i_wdata(s_axis_tdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kwsm_pkg::ST_IDLE: begin
                if (mrg_fire) n_state = kwsm_pkg::ST_READ;
            end
            kwsm_pkg::ST_READ: begin
                if (r_left == '0) n_state = kwsm_pkg::ST_EMPTY;
                else n_state = kwsm_pkg::ST_CHOOSE;
            end
            kwsm_pkg::ST_CHOOSE: begin
                if (scan_end) n_state = kwsm_pkg::ST_EMIT;
                else n_state = kwsm_pkg::ST_READ;
            end
            kwsm_pkg::ST_EMIT: begin
                if (out_fire) n_state = r_last ? kwsm_pkg::ST_IDLE : kwsm_pkg::ST_READ;
            end
            kwsm_pkg::ST_EMPTY: begin
                if (out_fire) n_state = kwsm_pkg::ST_IDLE;
            end
            default: n_state = kwsm_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        m_axis_tvalid = (r_state == kwsm_pkg::ST_EMIT) || (r_state == kwsm_pkg::ST_EMPTY);
        m_axis_tdata  = (r_state == kwsm_pkg::ST_EMPTY) ? 32'd0 : r_out;
        m_axis_tlast  = (r_state == kwsm_pkg::ST_EMPTY) ? 1'b1 : r_last;
        m_axis_tuser  = {r_drop, r_state == kwsm_pkg::ST_EMPTY};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= kwsm_pkg::ST_IDLE;
        else r_state <= n_state;
    end

    // Configuration, lengths and flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg  <= kwsm_pkg::ListsInUseReset;
            r_drop <= 1'b0;
            for (int i = 0; i < MAX_LISTS; i++) r_len[i] <= '0;
        end else begin
            if (cfg_we) r_cfg <= pwdata[2:0];
            if (app_fire) begin
                if (!sel_ok || full) r_drop <= 1'b1;
                else r_len[sel_l] <= r_len[sel_l] + 1'b1;
            end
            if (out_fire && m_axis_tlast) begin
                r_drop <= 1'b0;
                for (int i = 0; i < MAX_LISTS; i++) r_len[i] <= '0;
            end
        end
    end

    // Merge sequencer: scan heads in tournament order; a later list wins ties.
    always_ff @(posedge i_clk) begin
        logic [LW:0] nu;
        logic [CW+LW:0] tot;
        logic [LW+1:0] pw;
        logic [LW:0] diff;
        if (!i_rst_n) begin
            r_ptr <= '0; r_have <= 1'b0; r_left <= '0; r_nuse <= '0; r_start <= '0;
            for (int i = 0; i < MAX_LISTS; i++) r_pos[i] <= '0;
        end else begin
            if (mrg_fire) begin
                nu = (r_cfg == 3'd0) ? (LW+1)'(1) :
                     (32'(r_cfg) > MAX_LISTS) ? (LW+1)'(MAX_LISTS) : (LW+1)'(r_cfg);
                tot = '0;
                for (int i = 0; i < MAX_LISTS; i++)
                    if (i < 32'(nu)) tot = tot + (CW+LW+1)'(r_len[i]);
                // Largest power of two not above the list count.
                pw = (LW+2)'(1);
                for (int i = 0; i < LW; i++)
                    if ({pw[LW:0], 1'b0} <= (LW+2)'(nu)) pw = {pw[LW:0], 1'b0};
                diff = nu - pw[LW:0];
                r_start <= LW'({diff, 1'b0});
                r_nuse <= nu; r_left <= tot; r_ptr <= '0; r_have <= 1'b0;
                for (int i = 0; i < MAX_LISTS; i++) r_pos[i] <= '0;
            end
            if (r_state == kwsm_pkg::ST_CHOOSE) begin
                if (scan_end) begin
                    r_out  <= take ? rdata : r_bval;
                    r_pos[take ? cur : r_best] <= r_pos[take ? cur : r_best] + 1'b1;
                    r_last <= (r_left == (CW+LW+1)'(1));
                    r_left <= r_left - 1'b1;
                    r_ptr  <= '0;
                    r_have <= 1'b0;
                end else begin
                    if (take) begin
                        r_have <= 1'b1; r_bval <= rdata; r_best <= cur;
                    end
                    r_ptr <= r_ptr + 1'b1;
                end
            end
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_sorted_list_merge testbench
// Loads values into the lists with append requests, issues merge requests
// and checks every emitted value against a pairwise queue merge computed
// here, under several settings of the lists-in-use register.
// ----------------------------------------------------------------------------

// Holds the list contents as the block should and the merged values still due.
class merge_scoreboard;
    logic [31:0] lists [4][16];
    int          len [4];
    logic        dropped;
    logic [2:0]  lists_in_use;
    logic [34:0] due [$];      // {overflowed, empty_res, last, value}
    int          errors;

    function void clear_state();
        for (int i = 0; i < 4; i++) len[i] = 0;
        dropped      = 1'b0;
        lists_in_use = kwsm_pkg::ListsInUseReset;
        due.delete();
        errors       = 0;
    endfunction

    // Notes one accepted request and queues the values that it should produce.
    function void note_request(logic cmd, logic [1:0] sel, logic [31:0] val);
        logic [31:0] qbuf [4][64];
        int          qlen [4];
        logic [31:0] tmp [64];
        int          n, q, i, j, k;
        if (cmd == kwsm_pkg::CmdAppend) begin
            if (len[sel] >= 16) dropped = 1'b1;
            else begin
                lists[sel][len[sel]] = val;
                len[sel]++;
            end
            return;
        end
        n = (lists_in_use < 1) ? 1 : (lists_in_use > 4) ? 4 : lists_in_use;
        for (q = 0; q < n; q++) begin
            qlen[q] = len[q];
            for (i = 0; i < len[q]; i++) qbuf[q][i] = lists[q][i];
        end
        // Merge the first two sequences and append the result, until one is left.
        while (q > 1) begin
            i = 0; j = 0; k = 0;
            while (i < qlen[0] && j < qlen[1]) begin
                if ($signed(qbuf[0][i]) < $signed(qbuf[1][j])) begin
                    tmp[k] = qbuf[0][i]; i++;
                end else begin
                    tmp[k] = qbuf[1][j]; j++;
                end
                k++;
            end
            while (i < qlen[0]) begin tmp[k] = qbuf[0][i]; i++; k++; end
            while (j < qlen[1]) begin tmp[k] = qbuf[1][j]; j++; k++; end
            for (int e = 2; e < q; e++) begin
                for (int w = 0; w < qlen[e]; w++) qbuf[e - 2][w] = qbuf[e][w];
                qlen[e - 2] = qlen[e];
            end
            q = q - 2;
            for (int w = 0; w < k; w++) qbuf[q][w] = tmp[w];
            qlen[q] = k;
            q++;
        end
        if (qlen[0] == 0) due.insert(due.size(), {dropped, 1'b1, 1'b1, 32'd0});
        else
            for (i = 0; i < qlen[0]; i++)
                due.insert(due.size(), {dropped, 1'b0, i == qlen[0] - 1, qbuf[0][i]});
        for (i = 0; i < 4; i++) len[i] = 0;
        dropped = 1'b0;
    endfunction

    // Compares one emitted value with the oldest one due.
    function void check_result(logic [31:0] val, logic lst, logic emp, logic ovf);
        logic [34:0] exp_r;
        if (due.size() == 0) begin
            $display("%0t: unexpected result value %h last %b empty %b ovf %b",
                     $time, val, lst, emp, ovf);
            errors++;
            return;
        end
        exp_r = due.pop_front();
        if (exp_r[31:0] !== val)
            begin $display("%0t: value expected %h actual %h", $time, exp_r[31:0], val);
            errors++; end
        if (exp_r[32] !== lst)
            begin $display("%0t: last expected %b actual %b", $time, exp_r[32], lst);
            errors++; end
        if (exp_r[33] !== emp)
            begin $display("%0t: empty expected %b actual %b", $time, exp_r[33], emp);
            errors++; end
        if (exp_r[34] !== ovf)
            begin $display("%0t: overflow expected %b actual %b", $time, exp_r[34], ovf);
            errors++; end
    endfunction
endclass

module tb;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    merge_scoreboard board;
    int  cycles = 0;
    bit  calm = 1'b0;       // no idling in the last part of the run
    bit  hold_sink = 1'b0;  // long receiver hold-off requested

    k_way_sorted_list_merge DUT (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Give up if the run takes far longer than it should.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("k_way_sorted_list_merge test failed");
            $finish;
        end
    end

    // Check each accepted result and note each accepted request.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser[0], m_axis_tuser[1]);
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            board.note_request(s_axis_tuser[0], s_axis_tuser[2:1], s_axis_tdata);
    end

    // Receiver: random stalls in bursts, or a long hold-off when asked.
    initial begin
        int gap;
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(negedge i_clk);
                hold_sink = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 7);
                m_axis_tready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Sends one request and waits for its acceptance; the request stays
    // offered until the next one replaces it or the sender goes quiet.
    task automatic send(logic cmd, logic [1:0] sel, logic [31:0] val);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {sel, cmd};
        s_axis_tdata  <= val;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Stops offering requests, waits until every due result has come, then
    // lets the block settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.due.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // Writes the lists-in-use register through a setup and an access phase.
    task automatic write_lists_in_use(logic [2:0] n);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(4 * kwsm_pkg::RegListsInUse);
        pwdata <= {29'd0, n};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        board.lists_in_use = n;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return 32'($signed($urandom_range(0, 20)) - 10);
            default: return $urandom;
        endcase
    endfunction

    // One random set: appends of mostly rising runs mixed with random values, then a merge.
    task automatic random_set();
        int          cnt;
        logic [31:0] v;
        logic [1:0]  s;
        cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70) : $urandom_range(0, 12);
        for (int i = 0; i < cnt; i++) begin
            s = 2'($urandom_range(0, 3));
            v = ($urandom_range(0, 3) == 0) ? rand_value()
              : 32'(board.len[s] * 50 + $urandom_range(0, 60) - 400);
            send(kwsm_pkg::CmdAppend, s, v);
        end
        send(kwsm_pkg::CmdMerge, 2'($urandom), $urandom);
    endtask

    initial begin
        logic [2:0] settings [5] = '{3'd1, 3'd2, 3'd4, 3'd0, 3'd7};
        board = new();
        board.clear_state();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty merge at reset setting, extremes, ties, a full list.
        send(kwsm_pkg::CmdMerge, 2'd0, 32'd0);
        send(kwsm_pkg::CmdAppend, 2'd0, 32'h8000_0000);
        send(kwsm_pkg::CmdAppend, 2'd1, 32'h7FFF_FFFF);
        send(kwsm_pkg::CmdAppend, 2'd2, 32'h8000_0000);
        send(kwsm_pkg::CmdAppend, 2'd3, 32'hFFFF_FFFF);
        send(kwsm_pkg::CmdAppend, 2'd0, 32'd5);
        send(kwsm_pkg::CmdAppend, 2'd1, 32'd3);
        send(kwsm_pkg::CmdMerge, 2'd3, 32'hFFFF_FFFF);
        for (int i = 0; i < 18; i++) send(kwsm_pkg::CmdAppend, 2'd2, 32'(20 - i));
        send(kwsm_pkg::CmdMerge, 2'd0, 32'd0);
        drain();

        // Random sets under each register setting, extremes included.
        foreach (settings[k]) begin
            write_lists_in_use(settings[k]);
            if (k == 2) hold_sink = 1'b1;
            for (int j = 0; j < 3; j++) random_set();
            drain();
        end
        write_lists_in_use(3'd4);
        calm = 1'b1;
        for (int j = 0; j < 5; j++) random_set();
        drain();

        if (board.errors == 0 && board.due.size() == 0)
            $display("k_way_sorted_list_merge test passed");
        else
            $display("k_way_sorted_list_merge test failed");
        $finish;
    end
endmodule
